// File: rtl/tcw_pkg.sv
// Shared types, codes and constants of the text console writer.
`timescale 1ns / 1ps
package tcw_pkg;

  localparam int COLUMNS_DEFAULT  = 80;
  localparam int ROWS_DEFAULT     = 25;
  localparam int TAB_STOP_DEFAULT = 8;

  localparam int OP_W   = 2;
  localparam int CH_W   = 8;
  localparam int COLR_W = 4;
  localparam int ADDR_W = 11;
  localparam int LOC_W  = 11;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = 16;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [CH_W-1:0] CH_BS    = 8'h08;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_LAST  = 8'h7F;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CH_W-1:0]   ch;
    logic [COLR_W-1:0] back_color;
    logic [COLR_W-1:0] fore_color;
    logic [ADDR_W-1:0] cell_address;
  } tcw_in_t;

  typedef struct packed {
    logic [LOC_W-1:0]  cursor_location;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [CELL_W-1:0] cell_data;
    logic              did_scroll;
  } tcw_out_t;

  typedef struct packed {
    logic            put;
    logic            home;
    logic [CH_W-1:0] ch;
  } tcw_cur_cmd_t;

endpackage

// File: rtl/tcw_screen_ram.sv
// Screen cell memory with one write port and one registered read port.
`timescale 1ns / 1ps
module tcw_screen_ram
  import tcw_pkg::*;
#(
  parameter int DEPTH = COLUMNS_DEFAULT * ROWS_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [CELL_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/tcw_cursor.sv
// Cursor registers and the control code interpreter of a put operation.
`timescale 1ns / 1ps
module tcw_cursor
  import tcw_pkg::*;
#(
  parameter int COLUMNS  = COLUMNS_DEFAULT,
  parameter int ROWS     = ROWS_DEFAULT,
  parameter int TAB_STOP = TAB_STOP_DEFAULT,
  parameter int AW       = $clog2(COLUMNS * ROWS)
) (
  input  logic             clk,
  input  logic             rst,
  input  tcw_cur_cmd_t     cmd,
  output logic [AW-1:0]    cell_index,
  output logic             printable,
  output logic             scroll,
  output logic [LOC_W-1:0] cursor_location,
  output logic [ROW_W-1:0] cursor_row,
  output logic [COL_W-1:0] cursor_col
);

  localparam int CW  = $clog2(COLUMNS);
  localparam int CTW = $clog2(COLUMNS + TAB_STOP);
  localparam int LW  = $clog2(ROWS);
  localparam int LTW = $clog2(ROWS + 1);
  localparam int PW  = $clog2(TAB_STOP);

  logic [CW-1:0]  col;
  logic [LW-1:0]  line;
  logic [PW-1:0]  phase;
  logic [CW-1:0]  col_next;
  logic [LW-1:0]  line_next;
  logic [PW-1:0]  phase_next;
  logic [CTW-1:0] col_t;
  logic [LTW-1:0] line_t;
  logic [PW-1:0]  phase_t;

  assign cell_index = AW'(line) * AW'(COLUMNS) + AW'(col);
  assign printable  = (cmd.ch >= CH_SPACE) && (cmd.ch <= CH_LAST);

  assign cursor_location = LOC_W'(cell_index);
  assign cursor_row      = ROW_W'(line);
  assign cursor_col      = COL_W'(col);

  always_comb begin
    col_t   = CTW'(col);
    line_t  = LTW'(line);
    phase_t = phase;
    unique case (cmd.ch)
      CH_BS: begin
        if (col != '0) begin
          col_t   = CTW'(col) - 1'b1;
          phase_t = (phase == '0) ? PW'(TAB_STOP - 1) : phase - 1'b1;
        end
      end
      CH_TAB: begin
        col_t   = CTW'(col) + CTW'(TAB_STOP) - CTW'(phase);
        phase_t = '0;
      end
      CH_CR: begin
        col_t   = '0;
        phase_t = '0;
      end
      CH_LF: begin
        col_t   = '0;
        line_t  = LTW'(line) + 1'b1;
        phase_t = '0;
      end
      default: begin
        if (printable) begin
          col_t   = CTW'(col) + 1'b1;
          phase_t = (phase == PW'(TAB_STOP - 1)) ? '0 : phase + 1'b1;
        end
      end
    endcase
    if (col_t >= CTW'(COLUMNS)) begin
      col_t   = '0;
      line_t  = line_t + 1'b1;
      phase_t = '0;
    end
    scroll     = (line_t >= LTW'(ROWS));
    col_next   = CW'(col_t);
    phase_next = phase_t;
    line_next  = scroll ? LW'(ROWS - 1) : LW'(line_t);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.home) begin
      col   <= '0;
      line  <= '0;
      phase <= '0;
    end else if (cmd.put) begin
      col   <= col_next;
      line  <= line_next;
      phase <= phase_next;
    end
  end

endmodule

// File: rtl/text_console_writer.sv
// Top level of the text console writer: operation sequencer and sweep counter.
//
//   Channel   Signals                  Transfer
//   request   start, busy, request     start high and busy low at a rising edge
//   result    done, result             done high for one cycle, always taken
//
// Put without scroll and the unused op code: the result follows in the cycle after the transfer.
// Read: the cell comes from the registered read port of the screen memory and is registered in S_READ.
// Clear and a put that scrolls step one memory cell per cycle through the sweep counter: a clear
// blank-fills every cell; a scroll copies the rows up, then blank-fills the bottom row.
// After reset a clearing pass over all COLUMNS*ROWS cells (2000 by default) holds busy high.
// The receiver cannot stall; busy is low whenever a new request may be transferred.
`timescale 1ns / 1ps
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS  = COLUMNS_DEFAULT,
  parameter int ROWS     = ROWS_DEFAULT,
  parameter int TAB_STOP = TAB_STOP_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  tcw_in_t  request,
  output logic     done,
  output tcw_out_t result
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = (AW > ADDR_W) ? AW : ADDR_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_COPY,
    S_DRAIN,
    S_FILL
  } state_t;

  state_t            state;
  logic [AW-1:0]     ptr;
  logic              report;
  logic              rd_ok;
  logic              scroll_q;
  logic [CELL_W-1:0] data_q;

  logic              accept;
  tcw_cur_cmd_t      cur_cmd;
  logic [AW-1:0]     cell_index;
  logic              printable;
  logic              scroll;
  logic [LOC_W-1:0]  cur_location;
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [CELL_W-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [CELL_W-1:0] rdata;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign cur_cmd.put  = accept && (request.op == OP_PUT);
  assign cur_cmd.home = accept && (request.op == OP_CLEAR);
  assign cur_cmd.ch   = request.ch;

  tcw_cursor #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP),
    .AW       (AW)
  ) u_cursor (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cur_cmd),
    .cell_index      (cell_index),
    .printable       (printable),
    .scroll          (scroll),
    .cursor_location (cur_location),
    .cursor_row      (cur_row),
    .cursor_col      (cur_col)
  );

  always_comb begin
    we    = 1'b0;
    waddr = ptr;
    wdata = BLANK_CELL;
    raddr = ptr;
    unique case (state)
      S_IDLE: begin
        raddr = AW'(request.cell_address);
        if (cur_cmd.put && printable) begin
          we    = 1'b1;
          waddr = cell_index;
          wdata = {request.back_color, request.fore_color, request.ch};
        end
      end
      S_COPY: begin
        we    = (ptr != AW'(COLUMNS));
        waddr = AW'(ptr - AW'(COLUMNS + 1));
        wdata = rdata;
      end
      S_DRAIN: begin
        we    = 1'b1;
        waddr = AW'(CELLS - 1 - COLUMNS);
        wdata = rdata;
      end
      S_FILL: begin
        we = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  tcw_screen_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_FILL;
      ptr      <= '0;
      report   <= 1'b0;
      done     <= 1'b0;
      rd_ok    <= 1'b0;
      scroll_q <= 1'b0;
      data_q   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            data_q   <= '0;
            scroll_q <= 1'b0;
            report   <= 1'b1;
            unique case (request.op)
              OP_PUT: begin
                if (scroll) begin
                  scroll_q <= 1'b1;
                  ptr      <= AW'(COLUMNS);
                  state    <= S_COPY;
                end else begin
                  done <= 1'b1;
                end
              end
              OP_CLEAR: begin
                ptr   <= '0;
                state <= S_FILL;
              end
              OP_READ: begin
                rd_ok <= (RW'(request.cell_address) < RW'(CELLS));
                state <= S_READ;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_READ: begin
          data_q <= rd_ok ? rdata : '0;
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        S_COPY: begin
          if (ptr == AW'(CELLS - 1)) begin
            state <= S_DRAIN;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_DRAIN: begin
          ptr   <= AW'(CELLS - COLUMNS);
          state <= S_FILL;
        end
        S_FILL: begin
          if (ptr == AW'(CELLS - 1)) begin
            done  <= report;
            state <= S_IDLE;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result.cursor_location = cur_location;
  assign result.cursor_row      = cur_row;
  assign result.cursor_col      = cur_col;
  assign result.cell_data       = data_q;
  assign result.did_scroll      = scroll_q;

endmodule

// File: tb/text_console_writer_tb.sv
// Self-checking testbench for the text console writer: directed, line-oriented and random traffic.
`timescale 1ns / 1ps
module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int NCOLS = COLUMNS_DEFAULT;
  localparam int NROWS = ROWS_DEFAULT;
  localparam int TABW  = TAB_STOP_DEFAULT;
  localparam int CELLS = NCOLS * NROWS;

  localparam logic [OP_W-1:0] OP_UNUSED     = 2'd3;
  localparam logic [CH_W-1:0] CH_NUL        = 8'h00;
  localparam logic [CH_W-1:0] CH_UNIT_SEP   = 8'h1F;
  localparam logic [CH_W-1:0] CH_HIGH_FIRST = 8'h80;
  localparam logic [CH_W-1:0] CH_HIGH_LAST  = 8'hFF;

  localparam int QUIET_LIMIT  = 20000;
  localparam int REPORT_LIMIT = 10;

  logic     clk;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  tcw_in_t  request = '0;
  logic     done;
  tcw_out_t result;

  logic [CELL_W-1:0] screen_image [CELLS];
  int                cursor_x;
  int                cursor_y;
  tcw_out_t          pending_results [$];
  int                mismatch_count = 0;
  int                quiet_cycles = 0;
  int                burst_left = 0;

  text_console_writer dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void blank_screen_image();
    for (int i = 0; i < CELLS; i++) screen_image[i] = BLANK_CELL;
    cursor_x = 0;
    cursor_y = 0;
  endfunction

  function automatic tcw_out_t predict_console(tcw_in_t req);
    tcw_out_t          r;
    logic              scrolled;
    logic [CELL_W-1:0] data;
    r        = '0;
    scrolled = 1'b0;
    data     = '0;
    case (req.op)
      OP_PUT: begin
        if (req.ch == CH_BS) begin
          if (cursor_x != 0) cursor_x--;
        end else if (req.ch == CH_TAB) begin
          cursor_x = cursor_x + TABW - (cursor_x % TABW);
        end else if (req.ch == CH_CR) begin
          cursor_x = 0;
        end else if (req.ch == CH_LF) begin
          cursor_x = 0;
          cursor_y++;
        end else if (req.ch >= CH_SPACE && req.ch <= CH_LAST) begin
          screen_image[cursor_y * NCOLS + cursor_x] = {req.back_color, req.fore_color, req.ch};
          cursor_x++;
        end
        if (cursor_x >= NCOLS) begin
          cursor_x = 0;
          cursor_y++;
        end
        if (cursor_y >= NROWS) begin
          for (int i = 0; i < CELLS - NCOLS; i++) screen_image[i] = screen_image[i + NCOLS];
          for (int i = CELLS - NCOLS; i < CELLS; i++) screen_image[i] = BLANK_CELL;
          cursor_y = NROWS - 1;
          scrolled = 1'b1;
        end
      end
      OP_CLEAR: blank_screen_image();
      OP_READ: begin
        if (req.cell_address < CELLS) data = screen_image[req.cell_address];
      end
      default: ;
    endcase
    r.cursor_location = LOC_W'(cursor_y * NCOLS + cursor_x);
    r.cursor_row      = ROW_W'(cursor_y);
    r.cursor_col      = COL_W'(cursor_x);
    r.cell_data       = data;
    r.did_scroll      = scrolled;
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("%s", msg);
  endtask

  always @(posedge clk) begin : check_results
    tcw_out_t want;
    if (!rst) begin
      quiet_cycles++;
      if (done) begin
        quiet_cycles = 0;
        if (pending_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result: loc=%0d row=%0d col=%0d data=%h scroll=%b",
                                  result.cursor_location, result.cursor_row, result.cursor_col,
                                  result.cell_data, result.did_scroll));
        end else begin
          want = pending_results.pop_front();
          if (result.cursor_location !== want.cursor_location ||
              result.cursor_row !== want.cursor_row ||
              result.cursor_col !== want.cursor_col ||
              result.cell_data !== want.cell_data ||
              result.did_scroll !== want.did_scroll) begin
            flag_mismatch($sformatf(
              "mismatch: expected loc=%0d row=%0d col=%0d data=%h scroll=%b, got %0d %0d %0d %h %b",
              want.cursor_location, want.cursor_row, want.cursor_col, want.cell_data,
              want.did_scroll, result.cursor_location, result.cursor_row, result.cursor_col,
              result.cell_data, result.did_scroll));
          end
        end
      end
      if (start && !busy) begin
        quiet_cycles = 0;
        pending_results.push_back(predict_console(request));
      end
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("text_console_writer_tb: FAIL");
    $finish;
  end

  function automatic tcw_in_t random_fields();
    tcw_in_t it;
    it.op           = OP_W'($urandom_range(0, 3));
    it.ch           = CH_W'($urandom);
    it.back_color   = COLR_W'($urandom);
    it.fore_color   = COLR_W'($urandom);
    it.cell_address = ADDR_W'($urandom);
    return it;
  endfunction

  function automatic logic [CH_W-1:0] random_code();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return CH_W'($urandom_range(CH_SPACE, CH_LAST));
    if (sel < 78) return CH_LF;
    if (sel < 82) return CH_CR;
    if (sel < 86) return CH_BS;
    if (sel < 91) return CH_TAB;
    if (sel < 95) return CH_W'($urandom_range(CH_NUL, CH_UNIT_SEP));
    return CH_W'($urandom_range(CH_HIGH_FIRST, CH_HIGH_LAST));
  endfunction

  // The sender works in bursts; after each burst it may drop start for a random gap.
  task automatic send_item(input tcw_in_t item);
    int gap;
    start   <= 1'b1;
    request <= item;
    do @(posedge clk); while (busy);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic put_code(input logic [CH_W-1:0] code, input logic [COLR_W-1:0] back,
                          input logic [COLR_W-1:0] fore);
    tcw_in_t item;
    item            = random_fields();
    item.op         = OP_PUT;
    item.ch         = code;
    item.back_color = back;
    item.fore_color = fore;
    send_item(item);
  endtask

  task automatic read_cell(input int addr);
    tcw_in_t item;
    item              = random_fields();
    item.op           = OP_READ;
    item.cell_address = ADDR_W'(addr);
    send_item(item);
  endtask

  task automatic plain_op(input logic [OP_W-1:0] op);
    tcw_in_t item;
    item    = random_fields();
    item.op = op;
    send_item(item);
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_controls();
    read_cell(0);
    put_code(8'h41, 4'hF, 4'hF);
    put_code(CH_SPACE, 4'h0, 4'h0);
    put_code(CH_LAST, 4'hA, 4'h5);
    read_cell(0);
    read_cell(2);
    put_code(CH_BS, 4'h0, 4'h0);
    put_code(CH_CR, 4'h0, 4'h0);
    put_code(CH_BS, 4'h0, 4'h0);
    put_code(CH_TAB, 4'h0, 4'h0);
    put_code(CH_TAB, 4'h0, 4'h0);
    put_code(CH_LF, 4'h0, 4'h0);
    put_code(CH_NUL, 4'hF, 4'hF);
    put_code(CH_UNIT_SEP, 4'hF, 4'hF);
    put_code(CH_HIGH_FIRST, 4'hF, 4'hF);
    put_code(CH_HIGH_LAST, 4'hF, 4'hF);
    plain_op(OP_UNUSED);
    read_cell(CELLS - 1);
    read_cell(CELLS);
    read_cell(2 ** ADDR_W - 1);
    plain_op(OP_CLEAR);
    read_cell(0);
  endtask

  // Lines of text, a few long enough to wrap, pushed past the bottom row so the screen scrolls.
  task automatic test_lines_and_scroll();
    int                len;
    logic [COLR_W-1:0] bk;
    logic [COLR_W-1:0] fg;
    for (int n = 0; n < 40; n++) begin
      bk  = COLR_W'($urandom);
      fg  = COLR_W'($urandom);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(70, 170) : $urandom_range(0, 16);
      for (int k = 0; k < len; k++) put_code(CH_W'($urandom_range(CH_SPACE, CH_LAST)), bk, fg);
      if ($urandom_range(0, 3) == 0) put_code(CH_TAB, bk, fg);
      if ($urandom_range(0, 1) == 1) put_code(CH_CR, bk, fg);
      put_code(CH_LF, bk, fg);
      read_cell($urandom_range(CELLS - 2 * NCOLS, CELLS - 1));
      if ($urandom_range(0, 2) == 0) read_cell($urandom_range(0, CELLS - 1));
    end
  endtask

  task automatic test_clear_screen();
    for (int k = 0; k < 5; k++) put_code(CH_W'($urandom_range(CH_SPACE, CH_LAST)),
                                         COLR_W'($urandom), COLR_W'($urandom));
    put_code(CH_LF, 4'h0, 4'h0);
    plain_op(OP_CLEAR);
    read_cell(0);
    read_cell(CELLS - 1);
    put_code(8'h5A, 4'h3, 4'hC);
    read_cell(0);
  endtask

  task automatic test_random_traffic(input int count);
    int      sel;
    tcw_in_t item;
    for (int n = 0; n < count; n++) begin
      item = random_fields();
      sel  = $urandom_range(0, 999);
      if (sel < 10) begin
        item.op = OP_CLEAR;
      end else if (sel < 20) begin
        item.op = OP_UNUSED;
      end else if (sel < 130) begin
        item.op = OP_READ;
        sel     = $urandom_range(0, 9);
        if (sel < 5) item.cell_address = ADDR_W'($urandom_range(CELLS - 5 * NCOLS, CELLS - 1));
        else if (sel < 8) item.cell_address = ADDR_W'($urandom_range(0, CELLS - 1));
      end else begin
        item.op = OP_PUT;
        item.ch = random_code();
      end
      send_item(item);
    end
  endtask

  initial begin
    blank_screen_image();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_controls();
    test_lines_and_scroll();
    wait_all_results();
    test_clear_screen();
    test_random_traffic(900);
    wait_all_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("text_console_writer_tb: PASS");
    end else begin
      $display("text_console_writer_tb: FAIL");
    end
    $finish;
  end

endmodule
